@@ rtl/soft_viterbi_decoder_unit_defines.svh @@
// Assertion helpers for the soft Viterbi decoder
`ifndef SOFT_VITERBI_DECODER_UNIT_DEFINES_SVH
`define SOFT_VITERBI_DECODER_UNIT_DEFINES_SVH
// implication checked on every edge out of reset
`define SVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// implication checked in the cycle after the antecedent
`define SVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

@@ rtl/svd_pkg.sv @@
package svd_pkg;
    localparam int RATE        = 4;
    localparam int CONSTR_LEN  = 5;
    localparam int PATH_DEPTH  = 25;
    localparam int NSTATES     = 1 << (CONSTR_LEN - 1);
    localparam int NBFLY       = NSTATES / 2;
    localparam int SW          = $clog2(NSTATES);
    localparam int BW          = (NBFLY > 1) ? $clog2(NBFLY) : 1;
    localparam int PMW         = 24;
    localparam int CW          = 15;
    localparam int BMW         = CW + 2;
    localparam int STW         = $clog2(PATH_DEPTH);
    localparam int PW          = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int SOFT_MAX    = 16383;

    localparam logic [CFG_IDX_W-1:0] REG_POLY_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_D = 2'd3;

    typedef logic [PW-1:0] poly_t [4];

    // controller to datapath
    typedef struct packed {
        logic          load;      // capture samples, start a step
        logic          clear;     // restart decoder state
        logic          bfly_en;   // run one butterfly
        logic [BW-1:0] bfly_idx;
        logic          commit;    // new metrics and paths become current
        logic          emit;      // capture output bit
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic filled;             // step_count reached PATH_DEPTH-1
    } dp_sts_t;

    function automatic logic [CW-1:0] cost_of(input logic signed [15:0] x, input logic one);
        logic signed [16:0] c;
        logic signed [16:0] r;
        c = 17'(x);
        if (c > 17'sd16383) c = 17'sd16383;
        if (c < -17'sd16383) c = -17'sd16383;
        r = one ? (17'sd16383 - c) : (c + 17'sd16383);
        return r[CW-1:0];
    endfunction
endpackage

@@ rtl/svd_ctrl.sv @@
module svd_ctrl import svd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    action,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [BW-1:0] idx_reg, idx_next;
    logic          ov_reg, ov_next;
    logic          take;

    // a finished bit may wait while the next step runs; only a full slot stalls FIN
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.bfly_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (action)
                        cmd.clear = 1'b1;
                    else
                    begin
                        cmd.load   = 1'b1;
                        idx_next   = '0;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                cmd.bfly_en = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == BW'(NBFLY - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!(sts.filled && ov_next))
                begin
                    cmd.commit = 1'b1;
                    cmd.emit   = sts.filled;
                    if (sts.filled) ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

@@ rtl/svd_datapath.sv @@
module svd_datapath import svd_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  poly_t               poly,
    input  logic signed [15:0]  sample_0,
    input  logic signed [15:0]  sample_1,
    input  logic signed [15:0]  sample_2,
    input  logic signed [15:0]  sample_3,
    output dp_sts_t             sts,
    output logic                decoded_bit
);
    logic [CW-1:0]         cost_reg [4][2];
    logic [PMW-1:0]        pm_reg   [NSTATES];
    logic [PMW-1:0]        npm_reg  [NSTATES];
    logic [PATH_DEPTH-1:0] sv_reg   [NSTATES];
    logic [PATH_DEPTH-1:0] nsv_reg  [NSTATES];
    logic [STW-1:0]        step_reg;
    logic [PMW-1:0]        min_reg;
    logic [SW-1:0]         midx_reg;
    logic                  bit_reg;
    logic signed [15:0]    smp [4];

    assign smp[0] = sample_0;
    assign smp[1] = sample_1;
    assign smp[2] = sample_2;
    assign smp[3] = sample_3;
    assign sts.filled  = (step_reg == STW'(PATH_DEPTH - 1));
    assign decoded_bit = bit_reg;

    // one butterfly
    logic [SW-1:0]         ev, od;
    logic [BMW-1:0]        bm [2][2];     // [pred parity][new bit]
    logic [PMW-1:0]        m0 [2], m1 [2], win [2];
    logic                  pick [2];
    logic [PATH_DEPTH-1:0] low_mask;
    logic [PATH_DEPTH-1:0] nsv [2];
    logic [PMW-1:0]        bmin;
    logic [SW-1:0]         bidx;

    always_comb
    begin
        ev = {cmd.bfly_idx, 1'b0};
        od = {cmd.bfly_idx, 1'b1};
        for (int q = 0; q < 2; q++)
            for (int b = 0; b < 2; b++)
            begin
                bm[q][b] = '0;
                for (int p = 0; p < RATE; p++)
                    bm[q][b] = bm[q][b] + BMW'(cost_reg[p][
                        (^(ev & poly[p][SW-1:0])) ^ q[0] ^ b[0]]);
            end
        low_mask = (PATH_DEPTH'(1) << step_reg) - PATH_DEPTH'(1);
        for (int b = 0; b < 2; b++)
        begin
            m0[b]   = pm_reg[ev] + PMW'(bm[0][b]);
            m1[b]   = pm_reg[od] + PMW'(bm[1][b]);
            pick[b] = (m0[b] > m1[b]);
            win[b]  = pick[b] ? m1[b] : m0[b];
            nsv[b]  = ((pick[b] ? sv_reg[od] : sv_reg[ev]) & low_mask)
                      | (PATH_DEPTH'(b) << step_reg);
        end
        // lower half first, so ties keep the lowest index
        bmin = min_reg;
        bidx = midx_reg;
        if (win[0] < bmin || cmd.bfly_idx == '0)
        begin
            bmin = win[0];
            bidx = {1'b0, cmd.bfly_idx};
        end
    end

    // upper-half candidates are checked after all lower ones: hold them aside
    logic [PMW-1:0] hmin_reg;
    logic [SW-1:0]  hidx_reg;
    logic [PMW-1:0] fmin;
    logic [SW-1:0]  fidx;
    always_comb
    begin
        fmin = min_reg;
        fidx = midx_reg;
        if (hmin_reg < min_reg)
        begin
            fmin = hmin_reg;
            fidx = hidx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            for (int p = 0; p < 4; p++)
            begin
                cost_reg[p][0] <= cost_of(smp[p], 1'b0);
                cost_reg[p][1] <= cost_of(smp[p], 1'b1);
            end
        if (cmd.bfly_en)
        begin
            npm_reg[ev[SW-1:1]]                 <= win[0];
            npm_reg[{1'b1, cmd.bfly_idx}]       <= win[1];
            nsv_reg[ev[SW-1:1]]                 <= nsv[0];
            nsv_reg[{1'b1, cmd.bfly_idx}]       <= nsv[1];
            min_reg  <= bmin;
            midx_reg <= bidx;
            if (cmd.bfly_idx == '0 || win[1] < hmin_reg)
            begin
                hmin_reg <= win[1];
                hidx_reg <= {1'b1, cmd.bfly_idx};
            end
        end
        if (cmd.emit)
            bit_reg <= nsv_reg[fidx][0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            for (int s = 0; s < NSTATES; s++)
            begin
                pm_reg[s] <= '0;
                sv_reg[s] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            step_reg <= '0;
            for (int s = 0; s < NSTATES; s++)
            begin
                pm_reg[s] <= '0;
                sv_reg[s] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int s = 0; s < NSTATES; s++)
            begin
                pm_reg[s] <= npm_reg[s] - fmin;
                sv_reg[s] <= sts.filled ? (nsv_reg[s] >> 1) : nsv_reg[s];
            end
            if (!sts.filled)
                step_reg <= step_reg + 1'b1;
        end
    end
endmodule

@@ rtl/soft_viterbi_decoder_unit.sv @@
// Soft-decision Viterbi decoder, rate 1/RATE, 16 states, register-exchange paths.
// Input channel (in_valid/in_ready): one word per symbol group; action=1 restarts
// (metrics, paths, step count cleared, no output), action=0 decodes the samples.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): generator taps
// poly_a..poly_d at indices 0..3; write only while idle. Always ready.
// Output channel (out_valid/out_ready): decoded_bit, one word per decode item
// once PATH_DEPTH steps have filled the paths; none during filling.
// Sequence: a decode item is accepted, then its butterflies run on one shared
// butterfly unit, one butterfly a cycle, and then it commits; the bit shows on
// the output the cycle after commit. A restart clears the state as it is accepted.
// Stall: the result sits in an output register; the next item may be accepted and
// processed, and only a commit that emits waits while the previous bit is unread.
// Reset: async active low; taps, metrics, paths and step count clear.
`include "soft_viterbi_decoder_unit_defines.svh"
module soft_viterbi_decoder_unit import svd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic signed [15:0]   sample_0,
    input  logic signed [15:0]   sample_1,
    input  logic signed [15:0]   sample_2,
    input  logic signed [15:0]   sample_3,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 decoded_bit,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PW-1:0]        cfg_data
);
    poly_t   poly_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // tap registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int p = 0; p < 4; p++) poly_reg[p] <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POLY_A: poly_reg[0] <= cfg_data;
                REG_POLY_B: poly_reg[1] <= cfg_data;
                REG_POLY_C: poly_reg[2] <= cfg_data;
                REG_POLY_D: poly_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    svd_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .action,
        .out_valid, .out_ready, .sts, .cmd
    );

    svd_datapath u_dp (
        .clk, .rst_n, .cmd, .poly(poly_reg),
        .sample_0, .sample_1, .sample_2, .sample_3,
        .sts, .decoded_bit
    );

    // a commit never overwrites an unread bit
    `SVD_ASSERT_IMP(a_no_overrun, cmd.emit, !(out_valid && !out_ready))
    // emit only on a commit
    `SVD_ASSERT_IMP(a_emit_commit, cmd.emit, cmd.commit)
    // an emit raises out_valid
    `SVD_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid)
endmodule

@@ tb/sv/soft_viterbi_decoder_unit_tb.sv @@
`timescale 1ns / 100ps

// Testbench for the soft-decision Viterbi decoder.
// A predictor inside the testbench keeps its own path metrics and survivor paths.
// Each accepted input word updates the predictor, and any decoded bit is queued.
// The output monitor checks every accepted output bit against the oldest queued bit.
module soft_viterbi_decoder_unit_tb import svd_pkg::*; ();

    localparam int LIMIT = 4000;

    typedef struct {
        logic        act;
        logic [15:0] s [4];
        int          want;   // -1: predictor only, else typed-in bit
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, action;
    logic signed [15:0] sample_0, sample_1, sample_2, sample_3;
    logic out_valid, decoded_bit;
    logic out_ready = 1'b0;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PW-1:0] cfg_data;

    soft_viterbi_decoder_unit uut (.*);

    // predictor state
    logic [PW-1:0]         taps [4];
    logic [PMW-1:0]        metric [NSTATES];
    logic [PATH_DEPTH-1:0] paths [NSTATES];
    int                    steps;
    logic                  bits_due [$];

    int errors = 0;
    int idle_cycles = 0;
    bit quiet;          // no idling in the closing part
    bit hold_rx;        // long receiver hold-off
    row_t plan [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic exp_bit(input int st, input int p, input logic b);
        logic [PW-1:0] t;
        t = PW'(st & ~1) & taps[p] & PW'((1 << (CONSTR_LEN - 1)) - 1);
        return (^t) ^ logic'(st & 1) ^ b;
    endfunction

    // advance the trellis by one word, or restart it on a restart word; pushes a decoded bit when one is due
    task automatic decode_step(input logic act, input logic [15:0] smp [4]);
        int cost [4][2];
        int x, m0, m1, d, best, mi;
        logic [PMW-1:0] nm [NSTATES];
        logic [PATH_DEPTH-1:0] np [NSTATES];
        if (act)
        begin
            foreach (metric[k])
            begin
                metric[k] = '0;
                paths[k] = '0;
            end
            steps = 0;
            return;
        end
        for (int p = 0; p < 4; p++)
        begin
            x = $signed(smp[p]);
            if (x > SOFT_MAX) x = SOFT_MAX;
            if (x < -SOFT_MAX) x = -SOFT_MAX;
            cost[p][0] = x + SOFT_MAX;
            cost[p][1] = SOFT_MAX - x;
        end
        for (int i = 0; i < NSTATES / 2; i++)
            for (int b = 0; b < 2; b++)
            begin
                m0 = metric[2*i];
                m1 = metric[2*i+1];
                for (int p = 0; p < RATE; p++)
                begin
                    m0 += cost[p][exp_bit(2*i, p, b)];
                    m1 += cost[p][exp_bit(2*i+1, p, b)];
                end
                d = i + b * (NSTATES / 2);
                nm[d] = (m0 > m1) ? m1 : m0;
                np[d] = paths[(m0 > m1) ? 2*i+1 : 2*i];
                np[d][steps] = logic'(b);
            end
        best = nm[0];
        mi = 0;
        for (int k = 1; k < NSTATES; k++)
            if (nm[k] < best)
            begin
                best = nm[k];
                mi = k;
            end
        foreach (metric[k])
        begin
            metric[k] = nm[k] - best;
            paths[k] = np[k];
        end
        if (steps >= PATH_DEPTH - 1)
        begin
            bits_due.push_back(paths[mi][0]);
            foreach (paths[k]) paths[k] = paths[k] >> 1;
        end
        else
            steps++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        taps[idx] = val;
    endtask

    task automatic set_taps(input logic [PW-1:0] a, b, c, d);
        // settle: wait for all bits, then the block's own latency
        in_valid <= 1'b0;
        while (bits_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        write_reg(REG_POLY_A, a);
        write_reg(REG_POLY_B, b);
        write_reg(REG_POLY_C, c);
        write_reg(REG_POLY_D, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input row_t r);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= r.act;
        sample_0 <= r.s[0];
        sample_1 <= r.s[1];
        sample_2 <= r.s[2];
        sample_3 <= r.s[3];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n = bits_due.size();
        decode_step(r.act, r.s);
        if (r.want >= 0 && bits_due.size() > n)
            bits_due[$] = logic'(r.want[0]);
    endtask

    function automatic logic [15:0] rnd_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'd16383;
            3: return -16'sd16383;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic row_t mk(input logic act, input logic [15:0] v, input int want);
        row_t r;
        r.act = act;
        foreach (r.s[k]) r.s[k] = v;
        r.want = want;
        return r;
    endfunction

    function automatic row_t rnd_row(input int noise);
        row_t r;
        r.act = ($urandom_range(0, 99) < noise);
        foreach (r.s[k]) r.s[k] = rnd_sample();
        r.want = -1;
        return r;
    endfunction

    // output side: random stalls, one long hold-off, compare against the queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (bits_due.size() == 0)
                    report("decoded_bit with nothing expected");
                else
                begin
                    if (decoded_bit !== bits_due[0])
                        report($sformatf("decoded_bit got %b want %b",
                                         decoded_bit, bits_due[0]));
                    void'(bits_due.pop_front());
                end
            end
            if (hold_rx || (idle_cycles > 0))
            begin
                out_ready <= 1'b0;
                if (idle_cycles > 0) idle_cycles <= idle_cycles - 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                idle_cycles <= $urandom_range(0, 12);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    int stuck = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || hold_rx || !rst_n)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck > LIMIT)
        begin
            $display("soft_viterbi_decoder_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 1'b0;
        sample_0 = '0;
        sample_1 = '0;
        sample_2 = '0;
        sample_3 = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_rx = 1'b0;
        foreach (taps[k]) taps[k] = '0;
        decode_step(1'b1, '{default: '0});
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero taps straight from reset, extremes, restarts
        plan.push_back(mk(1'b1, 16'h0000, -1));
        for (int k = 0; k < 12; k++)
            plan.push_back(mk(1'b0, (k & 1) ? 16'h7fff : 16'h8000, -1));
        plan.push_back(mk(1'b0, 16'd16383, -1));
        plan.push_back(mk(1'b0, -16'sd16383, -1));
        plan.push_back(mk(1'b0, 16'd16384, -1));
        plan.push_back(mk(1'b0, 16'h0000, -1));
        for (int k = 0; k < 8; k++) plan.push_back(rnd_row(0));
        plan.push_back(mk(1'b1, 16'hffff, -1));
        foreach (plan[k]) send(plan[k]);

        set_taps(5'h13, 5'h1b, 5'h15, 5'h1f);
        for (int k = 0; k < 30; k++) send(mk(1'b0, 16'h7fff, -1));

        // long receiver hold-off while the sender keeps going
        fork
            begin
                hold_rx = 1'b1;
                repeat (200) @(posedge clk);
                hold_rx = 1'b0;
            end
            for (int k = 0; k < 6; k++) send(rnd_row(0));
        join

        // random phases under several tap settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_taps('1, '1, '1, '1);
                1: set_taps('0, '1, '0, '1);
                default: set_taps(PW'($urandom), PW'($urandom), PW'($urandom),
                                  PW'($urandom));
            endcase
            if (ph == 4) quiet = 1'b1;
            for (int k = 0; k < 90; k++) send(rnd_row(3));
        end

        in_valid <= 1'b0;
        while (bits_due.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("soft_viterbi_decoder_unit_tb OK");
        else
            $display("soft_viterbi_decoder_unit_tb NOT OK");
        $finish;
    end
endmodule

@@ soft_viterbi_decoder_unit.f @@
+incdir+rtl
rtl/svd_pkg.sv
rtl/svd_ctrl.sv
rtl/svd_datapath.sv
rtl/soft_viterbi_decoder_unit.sv
tb/sv/soft_viterbi_decoder_unit_tb.sv
